/* rtl/decimal_opcode_machine_step_defines.svh */
// Assertion helpers shared by the RTL modules.
// Both forms expect i_clk and i_rst_n in the enclosing module.
`ifndef DECIMAL_OPCODE_MACHINE_STEP_DEFINES_SVH
`define DECIMAL_OPCODE_MACHINE_STEP_DEFINES_SVH

// Same-cycle implication.
`define DOM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DOM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/dom_pkg.sv */
`default_nettype none

package dom_pkg;

    // Action codes of an input beat.
    localparam logic [1:0] FUNC_LOAD = 2'd0;
    localparam logic [1:0] FUNC_PUSH = 2'd1;
    localparam logic [1:0] FUNC_EXEC = 2'd2;

    // Sticky status codes.
    localparam logic [2:0] ERR_NONE   = 3'd0;
    localparam logic [2:0] ERR_OPCODE = 3'd1;
    localparam logic [2:0] ERR_MODE   = 3'd2;
    localparam logic [2:0] ERR_IMM    = 3'd3;
    localparam logic [2:0] ERR_RANGE  = 3'd4;
    localparam logic [2:0] ERR_FULL   = 3'd5;

    // Opcodes, the word value modulo one hundred.
    localparam logic [6:0] OP_ADD  = 7'd1;
    localparam logic [6:0] OP_MUL  = 7'd2;
    localparam logic [6:0] OP_IN   = 7'd3;
    localparam logic [6:0] OP_OUT  = 7'd4;
    localparam logic [6:0] OP_JT   = 7'd5;
    localparam logic [6:0] OP_JF   = 7'd6;
    localparam logic [6:0] OP_LT   = 7'd7;
    localparam logic [6:0] OP_EQ   = 7'd8;
    localparam logic [6:0] OP_ARB  = 7'd9;
    localparam logic [6:0] OP_HALT = 7'd99;

    // Operand modes; any digit above two maps to MODE_BAD.
    localparam logic [1:0] MODE_POS = 2'd0;
    localparam logic [1:0] MODE_IMM = 2'd1;
    localparam logic [1:0] MODE_REL = 2'd2;
    localparam logic [1:0] MODE_BAD = 2'd3;

    // Decimal decode: four remainder chains, eight word bits per cycle.
    localparam int DEC_W      = 17;
    localparam int DEC_BITS   = 8;
    localparam int DEC_CHAINS = 4;
    localparam logic [DEC_W-1:0] DEC_MOD [DEC_CHAINS] = '{
        17'd100, 17'd1000, 17'd10000, 17'd100000
    };

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_FETCH, S_WORD, S_DEC, S_CHECK, S_PRD,
        S_PRAW, S_IRD, S_IVAL, S_MUL, S_WB, S_DONE
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic clear;
        logic accept;
        logic rd_ip;
        logic cap_word;
        logic dec_step;
        logic check;
        logic rd_param;
        logic cap_raw;
        logic rd_ind;
        logic cap_ind;
        logic next_param;
        logic mul_step;
        logic wb;
        logic emit;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic clr_last;
        logic acc_exec;
        logic dec_done;
        logic chk_stop;
        logic cur_is_dest;
        logic cur_imm;
        logic last_param;
        logic is_mul;
        logic mul_done;
        logic slot_free;
    } t_status;

    // Shifts eight bits, most significant first, into a remainder modulo m.
    function automatic logic [DEC_W-1:0] dec_byte(input logic [DEC_W-1:0] r,
                                                  input logic [DEC_BITS-1:0] bits,
                                                  input logic [DEC_W-1:0] m);
        logic [DEC_W:0]   t;
        logic [DEC_W-1:0] acc;
        acc = r;
        for (int k = DEC_BITS - 1; k >= 0; k--) begin
            t = {acc, bits[k]};
            if (t >= {1'b0, m}) begin
                t = t - {1'b0, m};
            end
            acc = t[DEC_W-1:0];
        end
        return acc;
    endfunction

    // Leading decimal digit of r (r below ten units), folded to a mode code.
    function automatic logic [1:0] mode_code(input logic [DEC_W-1:0] r,
                                             input logic [DEC_W-1:0] u);
        logic [DEC_W+1:0] u1;
        logic [DEC_W+1:0] u2;
        logic [DEC_W+1:0] u3;
        logic [DEC_W+1:0] rr;
        u1 = {2'b00, u};
        u2 = u1 << 1;
        u3 = u1 + u2;
        rr = {2'b00, r};
        if (rr >= u3) begin
            return MODE_BAD;
        end else if (rr >= u2) begin
            return MODE_REL;
        end else if (rr >= u1) begin
            return MODE_IMM;
        end
        return MODE_POS;
    endfunction

endpackage

`default_nettype wire

/* rtl/dom_ram.sv */
`default_nettype none

module dom_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single port, registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/dom_ctrl.sv */
`default_nettype none
`include "decimal_opcode_machine_step_defines.svh"

module dom_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire dom_pkg::t_status i_st,
    output dom_pkg::t_cmd         o_cmd
);

    import dom_pkg::*;

    t_state r_state;
    t_state n_state;
    t_state exec_next;

    assign exec_next = i_st.is_mul ? S_MUL : S_WB;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_st.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_st.acc_exec ? S_FETCH : S_DONE;
                end
            end
            S_FETCH: n_state = S_WORD;
            S_WORD:  n_state = S_DEC;
            S_DEC: begin
                if (i_st.dec_done) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: n_state = i_st.chk_stop ? S_DONE : S_PRD;
            S_PRD:   n_state = S_PRAW;
            S_PRAW: begin
                if (i_st.cur_is_dest) begin
                    n_state = exec_next;
                end else if (i_st.cur_imm) begin
                    n_state = i_st.last_param ? exec_next : S_PRD;
                end else begin
                    n_state = S_IRD;
                end
            end
            S_IRD:  n_state = S_IVAL;
            S_IVAL: n_state = i_st.last_param ? exec_next : S_PRD;
            S_MUL: begin
                if (i_st.mul_done) begin
                    n_state = S_WB;
                end
            end
            S_WB:   n_state = S_DONE;
            S_DONE: begin
                if (i_st.slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_CLEAR: o_cmd.clear    = 1'b1;
            S_IDLE:  o_cmd.accept   = i_in_valid;
            S_FETCH: o_cmd.rd_ip    = 1'b1;
            S_WORD:  o_cmd.cap_word = 1'b1;
            S_DEC:   o_cmd.dec_step = 1'b1;
            S_CHECK: o_cmd.check    = 1'b1;
            S_PRD:   o_cmd.rd_param = 1'b1;
            S_PRAW: begin
                o_cmd.cap_raw    = 1'b1;
                o_cmd.next_param = i_st.cur_imm && !i_st.cur_is_dest && !i_st.last_param;
            end
            S_IRD:  o_cmd.rd_ind = 1'b1;
            S_IVAL: begin
                o_cmd.cap_ind    = 1'b1;
                o_cmd.next_param = !i_st.last_param;
            end
            S_MUL:  o_cmd.mul_step = 1'b1;
            S_WB:   o_cmd.wb       = 1'b1;
            S_DONE: o_cmd.emit     = i_st.slot_free;
            default: o_cmd = '0;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    `DOM_ASSERT_NXT(a_chk_stop_done, i_rst_n && (r_state == S_CHECK) && i_st.chk_stop, r_state == S_DONE, "faulting or halting check did not finish the beat")
    `DOM_ASSERT_IMP(a_emit_only_done, o_cmd.emit, r_state == S_DONE, "result emitted outside done state")

endmodule

`default_nettype wire

/* rtl/dom_dp.sv */
`default_nettype none
`include "decimal_opcode_machine_step_defines.svh"

module dom_dp #(
    parameter int MEM_WORDS   = 4096,
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire dom_pkg::t_cmd i_cmd,
    output dom_pkg::t_status   o_st,
    input  wire logic [1:0]    i_func,
    input  wire logic [11:0]   i_address,
    input  wire logic [63:0]   i_value,
    output logic               o_res_valid,
    input  wire logic          i_res_stall,
    output logic               o_out_valid,
    output logic [63:0]        o_out_value,
    output logic               o_halted,
    output logic               o_waiting,
    output logic [2:0]         o_status
);

    import dom_pkg::*;

    localparam int AW = $clog2(MEM_WORDS);
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam logic [63:0] MEM_LIM = 64'(MEM_WORDS);

    // Architectural state.
    logic [63:0]      r_ip;
    logic [63:0]      r_rb;
    logic [63:0]      r_q [QUEUE_DEPTH];
    logic [CW-1:0]    r_qcnt;
    logic [QW-1:0]    r_qhead;
    logic             r_halt;
    logic [2:0]       r_err;

    // Working registers of one instruction.
    logic [AW-1:0]    r_clr;
    logic             r_oob;
    logic [63:0]      r_word;
    logic             r_neg;
    logic [DEC_W-1:0] r_rem [DEC_CHAINS];
    logic [2:0]       r_dcnt;
    logic [1:0]       r_pidx;
    logic [63:0]      r_ptr;
    logic [63:0]      r_a;
    logic [63:0]      r_b;
    logic [1:0]       r_mstep;
    logic [63:0]      r_prod;
    logic [31:0]      r_mx;
    logic             r_ov;
    logic [63:0]      r_oval;
    logic             r_wt;

    // Result register.
    logic             r_res_valid;
    logic             r_res_ov;
    logic [63:0]      r_res_oval;
    logic             r_res_halt;
    logic             r_res_wait;
    logic [2:0]       r_res_status;

    // Memory port.
    logic             ram_we;
    logic [AW-1:0]    ram_addr;
    logic [63:0]      ram_wdata;
    logic [63:0]      ram_rdata;
    logic [63:0]      rd_val;
    logic             n_oob;

    dom_ram #(
        .WIDTH(64),
        .DEPTH(MEM_WORDS)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    assign rd_val = r_oob ? 64'd0 : ram_rdata;

    // Decode of the instruction word.
    logic [6:0]  op;
    logic [1:0]  m1;
    logic [1:0]  m2;
    logic [1:0]  m3;
    logic        op_ok;
    logic        has_dest;
    logic [1:0]  nparam;
    logic [1:0]  cur_mode;
    logic        last_param;
    logic        cur_is_dest;
    logic        q_empty;
    logic        chk_wait;
    logic [2:0]  chk_code;

    assign op = r_rem[0][6:0];
    assign m1 = mode_code(r_rem[1], DEC_MOD[0]);
    assign m2 = mode_code(r_rem[2], DEC_MOD[1]);
    assign m3 = mode_code(r_rem[3], DEC_MOD[2]);
    assign q_empty = (r_qcnt == '0);

    always_comb begin
        op_ok    = 1'b1;
        has_dest = 1'b0;
        nparam   = 2'd1;
        case (op)
            OP_ADD, OP_MUL, OP_LT, OP_EQ: begin
                has_dest = 1'b1;
                nparam   = 2'd3;
            end
            OP_IN:         has_dest = 1'b1;
            OP_OUT, OP_ARB: nparam  = 2'd1;
            OP_JT, OP_JF:  nparam   = 2'd2;
            OP_HALT:       nparam   = 2'd1;
            default:       op_ok    = 1'b0;
        endcase
    end

    // Check in model order: opcode, empty queue, then operand modes.
    always_comb begin
        chk_code = ERR_NONE;
        chk_wait = 1'b0;
        if (r_neg || !op_ok) begin
            chk_code = ERR_OPCODE;
        end else begin
            case (op)
                OP_ADD, OP_MUL, OP_LT, OP_EQ: begin
                    if (m1 == MODE_BAD || m2 == MODE_BAD) begin
                        chk_code = ERR_MODE;
                    end else if (m3 == MODE_IMM) begin
                        chk_code = ERR_IMM;
                    end else if (m3 == MODE_BAD) begin
                        chk_code = ERR_MODE;
                    end
                end
                OP_IN: begin
                    if (q_empty) begin
                        chk_wait = 1'b1;
                    end else if (m1 == MODE_IMM) begin
                        chk_code = ERR_IMM;
                    end else if (m1 == MODE_BAD) begin
                        chk_code = ERR_MODE;
                    end
                end
                OP_OUT, OP_ARB: begin
                    if (m1 == MODE_BAD) begin
                        chk_code = ERR_MODE;
                    end
                end
                OP_JT, OP_JF: begin
                    if (m1 == MODE_BAD || m2 == MODE_BAD) begin
                        chk_code = ERR_MODE;
                    end
                end
                default: chk_code = ERR_NONE;
            endcase
        end
    end

    always_comb begin
        case (r_pidx)
            2'd1:    cur_mode = m1;
            2'd2:    cur_mode = m2;
            default: cur_mode = m3;
        endcase
    end

    assign last_param  = (r_pidx == nparam);
    assign cur_is_dest = has_dest && last_param;

    // Queue tail and head arithmetic.
    logic [SW-1:0] tail_sum;
    logic [SW-1:0] tail_wrap;
    logic [QW-1:0] q_tail;
    logic [QW-1:0] head_inc;

    assign tail_sum  = SW'(r_qhead) + SW'(r_qcnt);
    assign tail_wrap = (tail_sum >= SW'(QUEUE_DEPTH)) ? tail_sum - SW'(QUEUE_DEPTH) : tail_sum;
    assign q_tail    = tail_wrap[QW-1:0];
    assign head_inc  = (r_qhead == QW'(QUEUE_DEPTH - 1)) ? '0 : r_qhead + 1'b1;

    // Address arithmetic.
    logic [63:0] p_addr;
    logic [63:0] ind_base;
    logic [63:0] ld_addr;
    logic        ld_ok;
    logic        ptr_ok;

    assign p_addr   = r_ip + {62'd0, r_pidx};
    assign ind_base = rd_val + ((cur_mode == MODE_REL) ? r_rb : 64'd0);
    assign ld_addr  = {52'd0, i_address};
    assign ld_ok    = (ld_addr < MEM_LIM);
    assign ptr_ok   = (r_ptr < MEM_LIM);

    // Shared 32x32 multiplier for the three partial products.
    logic [31:0] mul_x;
    logic [31:0] mul_y;
    logic [63:0] mul_p;

    always_comb begin
        case (r_mstep)
            2'd0: begin
                mul_x = r_a[31:0];
                mul_y = r_b[31:0];
            end
            2'd1: begin
                mul_x = r_a[31:0];
                mul_y = r_b[63:32];
            end
            default: begin
                mul_x = r_a[63:32];
                mul_y = r_b[31:0];
            end
        endcase
    end

    assign mul_p = mul_x * mul_y;

    // Arithmetic result.
    logic [63:0] x_res;
    logic [63:0] st_val;

    always_comb begin
        case (op)
            OP_ADD:  x_res = r_a + r_b;
            OP_MUL:  x_res = r_prod + {r_mx, 32'd0};
            OP_LT:   x_res = ($signed(r_a) < $signed(r_b)) ? 64'd1 : 64'd0;
            OP_EQ:   x_res = (r_a == r_b) ? 64'd1 : 64'd0;
            default: x_res = 64'd0;
        endcase
    end

    assign st_val = (op == OP_IN) ? r_q[r_qhead] : x_res;

    // Memory port selection.
    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = r_ptr[AW-1:0];
        ram_wdata = st_val;
        n_oob     = 1'b0;
        if (i_cmd.clear) begin
            ram_we    = 1'b1;
            ram_addr  = r_clr;
            ram_wdata = 64'd0;
        end else if (i_cmd.accept && i_func == FUNC_LOAD) begin
            ram_we    = ld_ok;
            ram_addr  = ld_addr[AW-1:0];
            ram_wdata = i_value;
        end else if (i_cmd.rd_ip) begin
            ram_addr = r_ip[AW-1:0];
            n_oob    = (r_ip >= MEM_LIM);
        end else if (i_cmd.rd_param) begin
            ram_addr = p_addr[AW-1:0];
            n_oob    = (p_addr >= MEM_LIM);
        end else if (i_cmd.rd_ind) begin
            n_oob = !ptr_ok;
        end else if (i_cmd.wb) begin
            ram_we = has_dest && ptr_ok;
        end
    end

    // Decimal remainder chains.
    logic [DEC_W-1:0] n_rem [DEC_CHAINS];

    always_comb begin
        for (int c = 0; c < DEC_CHAINS; c++) begin
            n_rem[c] = dec_byte(r_rem[c], r_word[63 -: DEC_BITS], DEC_MOD[c]);
        end
    end

    // Memory clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clear) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    // Instruction working registers.
    always_ff @(posedge i_clk) begin
        r_oob <= n_oob;
        if (i_cmd.cap_word) begin
            r_word <= rd_val;
            r_neg  <= rd_val[63];
            for (int c = 0; c < DEC_CHAINS; c++) begin
                r_rem[c] <= '0;
            end
        end else if (i_cmd.dec_step) begin
            r_word <= r_word << DEC_BITS;
            for (int c = 0; c < DEC_CHAINS; c++) begin
                r_rem[c] <= n_rem[c];
            end
        end
        if (i_cmd.cap_raw) begin
            r_ptr <= ind_base;
        end
        if ((i_cmd.cap_raw && cur_mode == MODE_IMM && !cur_is_dest) || i_cmd.cap_ind) begin
            if (r_pidx == 2'd1) begin
                r_a <= rd_val;
            end else begin
                r_b <= rd_val;
            end
        end
        if (i_cmd.mul_step) begin
            case (r_mstep)
                2'd0:    r_prod <= mul_p;
                2'd1:    r_mx   <= mul_p[31:0];
                default: r_mx   <= r_mx + mul_p[31:0];
            endcase
        end
        if (i_cmd.accept) begin
            r_oval <= 64'd0;
        end else if (i_cmd.wb && op == OP_OUT) begin
            r_oval <= r_a;
        end
    end

    // Control counters and per-beat flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt  <= '0;
            r_pidx  <= 2'd1;
            r_mstep <= '0;
            r_ov    <= 1'b0;
            r_wt    <= 1'b0;
        end else begin
            if (i_cmd.cap_word) begin
                r_dcnt <= '0;
            end else if (i_cmd.dec_step) begin
                r_dcnt <= r_dcnt + 1'b1;
            end
            if (i_cmd.check) begin
                r_pidx  <= 2'd1;
                r_mstep <= '0;
            end else begin
                if (i_cmd.next_param) begin
                    r_pidx <= r_pidx + 1'b1;
                end
                if (i_cmd.mul_step) begin
                    r_mstep <= r_mstep + 1'b1;
                end
            end
            if (i_cmd.accept) begin
                r_ov <= 1'b0;
                r_wt <= 1'b0;
            end else begin
                if (i_cmd.check) begin
                    r_wt <= chk_wait;
                end
                if (i_cmd.wb && op == OP_OUT) begin
                    r_ov <= 1'b1;
                end
            end
        end
    end

    // Architectural registers: pointers, queue, flags.
    logic       push_do;
    logic       pop_do;
    logic       wb_fail;
    logic [2:0] raise;

    assign push_do = i_cmd.accept && i_func == FUNC_PUSH && (r_qcnt < CW'(QUEUE_DEPTH));
    assign wb_fail = i_cmd.wb && has_dest && !ptr_ok;
    assign pop_do  = i_cmd.wb && op == OP_IN && ptr_ok;

    always_comb begin
        raise = ERR_NONE;
        if (i_cmd.accept && i_func == FUNC_PUSH && !push_do) begin
            raise = ERR_FULL;
        end else if (i_cmd.check) begin
            raise = chk_code;
        end else if (wb_fail) begin
            raise = ERR_RANGE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_do) begin
            r_q[q_tail] <= i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ip    <= '0;
            r_rb    <= '0;
            r_qcnt  <= '0;
            r_qhead <= '0;
            r_halt  <= 1'b0;
            r_err   <= ERR_NONE;
        end else begin
            if (r_err == ERR_NONE) begin
                r_err <= raise;
            end
            if (i_cmd.check && chk_code == ERR_NONE && !r_neg && op == OP_HALT) begin
                r_halt <= 1'b1;
            end
            if (push_do) begin
                r_qcnt <= r_qcnt + 1'b1;
            end else if (pop_do) begin
                r_qcnt  <= r_qcnt - 1'b1;
                r_qhead <= head_inc;
            end
            if (i_cmd.wb && !wb_fail) begin
                case (op)
                    OP_ADD, OP_MUL, OP_LT, OP_EQ: r_ip <= r_ip + 64'd4;
                    OP_IN, OP_OUT:                r_ip <= r_ip + 64'd2;
                    OP_ARB: begin
                        r_ip <= r_ip + 64'd2;
                        r_rb <= r_rb + r_a;
                    end
                    OP_JT: r_ip <= (r_a != 64'd0) ? r_b : r_ip + 64'd3;
                    OP_JF: r_ip <= (r_a == 64'd0) ? r_b : r_ip + 64'd3;
                    default: r_ip <= r_ip;
                endcase
            end
        end
    end

    // Result register, loaded once the slot is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_res_valid <= 1'b1;
        end else if (!i_res_stall) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_res_ov     <= r_ov;
            r_res_oval   <= r_oval;
            r_res_halt   <= r_halt;
            r_res_wait   <= r_wt;
            r_res_status <= r_err;
        end
    end

    // Status to the controller.
    always_comb begin
        o_st             = '0;
        o_st.clr_last    = (r_clr == AW'(MEM_WORDS - 1));
        o_st.acc_exec    = (i_func == FUNC_EXEC) && !r_halt && (r_err == ERR_NONE);
        o_st.dec_done    = (r_dcnt == 3'd7);
        o_st.chk_stop    = (chk_code != ERR_NONE) || chk_wait || (op == OP_HALT) || r_neg;
        o_st.cur_is_dest = cur_is_dest;
        o_st.cur_imm     = (cur_mode == MODE_IMM);
        o_st.last_param  = last_param;
        o_st.is_mul      = (op == OP_MUL);
        o_st.mul_done    = (r_mstep == 2'd2);
        o_st.slot_free   = !r_res_valid || !i_res_stall;
    end

    assign o_res_valid = r_res_valid;
    assign o_out_valid = r_res_ov;
    assign o_out_value = r_res_oval;
    assign o_halted    = r_res_halt;
    assign o_waiting   = r_res_wait;
    assign o_status    = r_res_status;

    `DOM_ASSERT_IMP(a_qcnt_bound, 1'b1, r_qcnt <= CW'(QUEUE_DEPTH), "queue count above depth")
    `DOM_ASSERT_NXT(a_err_sticky, i_rst_n && (r_err != ERR_NONE), r_err == $past(r_err), "error code changed after being set")
    `DOM_ASSERT_NXT(a_halt_sticky, i_rst_n && r_halt, r_halt, "halt flag cleared without reset")

endmodule

`default_nettype wire

/* rtl/decimal_opcode_machine_step.sv */
// Load and push beats, and execute beats on a halted or faulted machine, go straight from
// acceptance to the done state and the result handshake. A running execute beat makes one
// fetch and a decimal decode, then up to six reads in all and one write on the
// single memory port. A multiply forms three partial products on the shared 32x32 multiplier.
// One beat is in work at a time; a stalled result holds off the next beat.
// After reset a clearing pass writes zero to every memory word.
`default_nettype none

module decimal_opcode_machine_step #(
    parameter int MEM_WORDS   = 4096,
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_func,
    input  wire logic [11:0] i_address,
    input  wire logic [63:0] i_value,
    output logic             o_res_valid,
    input  wire logic        i_res_stall,
    output logic             o_out_valid,
    output logic [63:0]      o_out_value,
    output logic             o_halted,
    output logic             o_waiting,
    output logic [2:0]       o_status
);

    import dom_pkg::*;

    t_cmd    cmd;
    t_status st;

    dom_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_st      (st),
        .o_cmd     (cmd)
    );

    dom_dp #(
        .MEM_WORDS  (MEM_WORDS),
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_st       (st),
        .i_func     (i_func),
        .i_address  (i_address),
        .i_value    (i_value),
        .o_res_valid(o_res_valid),
        .i_res_stall(i_res_stall),
        .o_out_valid(o_out_valid),
        .o_out_value(o_out_value),
        .o_halted   (o_halted),
        .o_waiting  (o_waiting),
        .o_status   (o_status)
    );

endmodule

`default_nettype wire

/* tb/decimal_opcode_machine_step_tb.sv */
`timescale 1ns / 100ps

module decimal_opcode_machine_step_tb;
    import dom_pkg::*;

    localparam int MEM_WORDS   = 4096;
    localparam int QUEUE_DEPTH = 16;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [1:0]  func;
        logic [11:0] addr;
        logic [63:0] value;
    } t_beat;

    typedef struct {
        logic        ov;
        logic [63:0] oval;
        logic        halted;
        logic        waiting;
        logic [2:0]  status;
    } t_res;

    // Shadow machine and the list of results it still owes.
    class t_machine_sb;
        logic [63:0] mem [MEM_WORDS];
        logic [63:0] ip;
        logic [63:0] rb;
        logic [63:0] iq [QUEUE_DEPTH];
        int          qcnt;
        int          qhead;
        logic        halt;
        logic [2:0]  err;
        t_res        owed [$];
        int          n_in;
        int          errors;

        function new();
            foreach (mem[i]) mem[i] = '0;
            foreach (iq[i]) iq[i] = '0;
            ip = '0;
            rb = '0;
            qcnt = 0;
            qhead = 0;
            halt = 1'b0;
            err = ERR_NONE;
            n_in = 0;
            errors = 0;
        endfunction

        function logic [63:0] rd(logic [63:0] a);
            return (a < MEM_WORDS) ? mem[a[11:0]] : 64'd0;
        endfunction

        function int mode_of(logic [63:0] w, int p);
            logic [63:0] m;
            m = w / 100;
            for (int k = 1; k < p; k++) m = m / 10;
            return int'(m % 10);
        endfunction

        function void raise_err(logic [2:0] e);
            if (err == ERR_NONE) err = e;
        endfunction

        function logic [2:0] fetch(logic [63:0] w, int p, output logic [63:0] v);
            int          md;
            logic [63:0] raw;
            md = mode_of(w, p);
            raw = rd(ip + p);
            v = '0;
            case (md)
                0: v = rd(raw);
                1: v = raw;
                2: v = rd(raw + rb);
                default: return ERR_MODE;
            endcase
            return ERR_NONE;
        endfunction

        function logic [2:0] store(logic [63:0] w, int p, logic [63:0] v);
            int          md;
            logic [63:0] a;
            md = mode_of(w, p);
            a = rd(ip + p);
            if (md == 1) return ERR_IMM;
            if (md == 2) a = a + rb;
            else if (md != 0) return ERR_MODE;
            if (a >= MEM_WORDS) return ERR_RANGE;
            mem[a[11:0]] = v;
            return ERR_NONE;
        endfunction

        // One instruction at the current pointer.
        function void run_instr(output logic ov, output logic [63:0] outv,
                                output logic wt);
            logic [63:0] w;
            logic [63:0] a;
            logic [63:0] b;
            logic [63:0] x;
            logic [2:0]  e;
            int          op;
            w = rd(ip);
            a = '0;
            b = '0;
            x = '0;
            e = ERR_NONE;
            ov = 1'b0;
            outv = '0;
            wt = 1'b0;
            if (w[63]) begin
                raise_err(ERR_OPCODE);
                return;
            end
            op = int'(w % 100);
            case (op)
                OP_ADD, OP_MUL, OP_LT, OP_EQ: begin
                    e = fetch(w, 1, a);
                    if (e == ERR_NONE) e = fetch(w, 2, b);
                    if (e == ERR_NONE) begin
                        if (op == OP_ADD) x = a + b;
                        else if (op == OP_MUL) x = a * b;
                        else if (op == OP_LT) x = ($signed(a) < $signed(b)) ? 64'd1 : 64'd0;
                        else x = (a == b) ? 64'd1 : 64'd0;
                        e = store(w, 3, x);
                    end
                    if (e != ERR_NONE) raise_err(e);
                    else ip = ip + 4;
                end
                OP_IN: begin
                    if (qcnt == 0) begin
                        wt = 1'b1;
                    end else begin
                        e = store(w, 1, iq[qhead]);
                        if (e != ERR_NONE) begin
                            raise_err(e);
                        end else begin
                            qhead = (qhead + 1) % QUEUE_DEPTH;
                            qcnt--;
                            ip = ip + 2;
                        end
                    end
                end
                OP_OUT: begin
                    e = fetch(w, 1, a);
                    if (e != ERR_NONE) begin
                        raise_err(e);
                    end else begin
                        ov = 1'b1;
                        outv = a;
                        ip = ip + 2;
                    end
                end
                OP_JT, OP_JF: begin
                    e = fetch(w, 1, a);
                    if (e == ERR_NONE) e = fetch(w, 2, b);
                    if (e != ERR_NONE) raise_err(e);
                    else if ((op == OP_JT) == (a != 0)) ip = b;
                    else ip = ip + 3;
                end
                OP_ARB: begin
                    e = fetch(w, 1, a);
                    if (e != ERR_NONE) begin
                        raise_err(e);
                    end else begin
                        rb = rb + a;
                        ip = ip + 2;
                    end
                end
                OP_HALT: halt = 1'b1;
                default: raise_err(ERR_OPCODE);
            endcase
        endfunction

        // Accepted input beat: update the shadow state and owe one result.
        function void note_beat(t_beat bt);
            t_res r;
            r.ov = 1'b0;
            r.oval = '0;
            r.waiting = 1'b0;
            n_in++;
            case (bt.func)
                FUNC_LOAD: mem[bt.addr] = bt.value;
                FUNC_PUSH: begin
                    if (qcnt >= QUEUE_DEPTH) begin
                        raise_err(ERR_FULL);
                    end else begin
                        iq[(qhead + qcnt) % QUEUE_DEPTH] = bt.value;
                        qcnt++;
                    end
                end
                FUNC_EXEC: begin
                    if (!halt && err == ERR_NONE) run_instr(r.ov, r.oval, r.waiting);
                end
                default: ;
            endcase
            r.halted = halt;
            r.status = err;
            owed.push_back(r);
        endfunction

        task report(string s);
            $display("ERROR at %0t: %s", $time, s);
            errors++;
        endtask

        task check_result(t_res got);
            t_res e;
            if (owed.size() == 0) begin
                report("result beat with nothing expected");
                return;
            end
            e = owed.pop_front();
            if (got.ov !== e.ov)
                report($sformatf("out_valid %b, expected %b", got.ov, e.ov));
            if (got.oval !== e.oval)
                report($sformatf("out_value %h, expected %h", got.oval, e.oval));
            if (got.halted !== e.halted)
                report($sformatf("halted %b, expected %b", got.halted, e.halted));
            if (got.waiting !== e.waiting)
                report($sformatf("waiting %b, expected %b", got.waiting, e.waiting));
            if (got.status !== e.status)
                report($sformatf("status %0d, expected %0d", got.status, e.status));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_func;
    logic [11:0] i_address;
    logic [63:0] i_value;
    logic        o_res_valid;
    logic        i_res_stall;
    logic        o_out_valid;
    logic [63:0] o_out_value;
    logic        o_halted;
    logic        o_waiting;
    logic [2:0]  o_status;

    decimal_opcode_machine_step dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_func      (i_func),
        .i_address   (i_address),
        .i_value     (i_value),
        .o_res_valid (o_res_valid),
        .i_res_stall (i_res_stall),
        .o_out_valid (o_out_valid),
        .o_out_value (o_out_value),
        .o_halted    (o_halted),
        .o_waiting   (o_waiting),
        .o_status    (o_status)
    );

    t_machine_sb sb;
    t_beat       pend [$];
    int          issued;
    int          gen_phase;
    int          dir_idx;
    bit          drive_done;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Mix of boundary values, small values and full random words.
    function automatic logic [63:0] pick_value();
        case ($urandom % 7)
            0: return 64'd0;
            1: return 64'h7fff_ffff_ffff_ffff;
            2: return 64'h8000_0000_0000_0000;
            3: return '1;
            4: return 64'($urandom_range(0, 20));
            default: return rand64();
        endcase
    endfunction

    function automatic void add_beat(logic [1:0] f, logic [11:0] a, logic [63:0] v);
        t_beat b;
        b.func = f;
        b.addr = a;
        b.value = v;
        pend.push_back(b);
    endfunction

    // Source operand word for a given mode.
    function automatic logic [63:0] src_word(int md);
        if (md == 0) begin
            if ($urandom % 10 == 0) return rand64() | 64'h1000;
            return 64'($urandom_range(0, MEM_WORDS - 1));
        end
        if (md == 1) return pick_value();
        return 64'($urandom_range(0, MEM_WORDS - 1)) - sb.rb;
    endfunction

    // Loads an instruction and its operands at the pointer, then executes it.
    function automatic void put_instr(logic [63:0] w, logic [63:0] ops [3], int n);
        logic [63:0] base;
        base = sb.ip;
        add_beat(FUNC_LOAD, base[11:0], w);
        for (int k = 0; k < n; k++) add_beat(FUNC_LOAD, 12'(base + k + 1), ops[k]);
        add_beat(FUNC_EXEC, 12'($urandom), rand64());
    endfunction

    function automatic void gen_instr(int op, bit want_wait);
        int          md [3];
        logic [63:0] ops [3];
        logic [63:0] w;
        int          n;
        int          dst;
        foreach (md[i]) md[i] = $urandom_range(0, 9);
        foreach (ops[i]) ops[i] = rand64();
        dst = -1;
        case (op)
            OP_ADD, OP_MUL, OP_LT, OP_EQ: begin n = 3; dst = 2; end
            OP_IN: begin n = 1; dst = 0; end
            OP_JT, OP_JF: n = 2;
            default: n = 1;
        endcase
        for (int k = 0; k < n; k++) begin
            if (k == dst) begin
                md[k] = ($urandom % 2) ? 2 : 0;
                ops[k] = 64'($urandom_range(0, MEM_WORDS - 1));
                if (md[k] == 2) ops[k] = ops[k] - sb.rb;
            end else begin
                md[k] = $urandom_range(0, 2);
                ops[k] = src_word(md[k]);
            end
        end
        if (op == OP_JT || op == OP_JF) begin
            md[1] = 1;
            ops[1] = 64'($urandom_range(0, 4000));
            if (md[0] == 1 && $urandom % 2) ops[0] = 64'd0;
            // Near the top of memory the jump must be taken.
            if (sb.ip > 4000) begin
                md[0] = 1;
                ops[0] = (op == OP_JT) ? 64'd1 : 64'd0;
            end
        end
        if (op == OP_ARB && md[0] == 1 && $urandom % 4 != 0)
            ops[0] = 64'(signed'($urandom_range(0, 200) - 100));
        if (op == OP_IN && sb.qcnt == 0 && !want_wait)
            add_beat(FUNC_PUSH, 12'($urandom), pick_value());
        w = 64'(op) + 100 * md[0] + 1000 * md[1] + 10000 * md[2];
        if ($urandom % 4 == 0) w = w + 100000 * 64'($urandom_range(0, 99999));
        put_instr(w, ops, n);
    endfunction

    // Stray beats: loads anywhere, pushes, and the unused action code.
    function automatic void gen_noise();
        case ($urandom % 3)
            0: add_beat(FUNC_LOAD, 12'($urandom), pick_value());
            1: add_beat(2'd3, 12'($urandom), rand64());
            default: begin
                if (sb.qcnt < 12) add_beat(FUNC_PUSH, 12'($urandom), pick_value());
            end
        endcase
    endfunction

    // Drives the machine into one sticky stop, then checks that it stays there.
    function automatic void gen_fault();
        logic [63:0] ops [3];
        logic [63:0] w;
        foreach (ops[i]) ops[i] = 64'($urandom_range(0, 50));
        case ($urandom % 7)
            0: put_instr(rand64() | 64'h8000_0000_0000_0000, ops, 0);
            1: begin
                w = ($urandom % 2) ? 64'd0 : 64'($urandom_range(10, 98));
                put_instr(w + 100 * 64'($urandom_range(0, 999)), ops, 0);
            end
            2: put_instr(64'(OP_ADD) + 100 * $urandom_range(3, 9), ops, 3);
            3: put_instr(64'(OP_ADD) + 1100 + 10000, ops, 3);
            4: begin
                ops[2] = 64'(MEM_WORDS) + $urandom_range(0, 1000);
                put_instr(64'(OP_ADD) + 1100, ops, 3);
            end
            5: begin
                for (int k = sb.qcnt; k <= QUEUE_DEPTH; k++)
                    add_beat(FUNC_PUSH, 12'($urandom), pick_value());
            end
            default: put_instr(64'(OP_HALT) + 100 * 64'($urandom_range(0, 999)), ops, 0);
        endcase
        for (int k = 0; k < 30; k++) add_beat(2'($urandom), 12'($urandom), pick_value());
    endfunction

    function automatic void refill();
        int ops_all [9];
        ops_all = '{OP_ADD, OP_MUL, OP_IN, OP_OUT, OP_JT, OP_JF, OP_LT, OP_EQ, OP_ARB};
        if (gen_phase == 0) begin
            // Directed: input on an empty queue, then every operation but halt once.
            case (dir_idx)
                0: gen_instr(OP_IN, 1'b1);
                1: gen_instr(OP_IN, 1'b0);
                2: gen_instr(OP_ADD, 1'b0);
                3: gen_instr(OP_MUL, 1'b0);
                4: gen_instr(OP_OUT, 1'b0);
                5: gen_instr(OP_JT, 1'b0);
                6: gen_instr(OP_JF, 1'b0);
                7: gen_instr(OP_LT, 1'b0);
                8: gen_instr(OP_EQ, 1'b0);
                9: gen_instr(OP_ARB, 1'b0);
                default: begin
                    add_beat(2'd3, 12'hfff, '1);
                    add_beat(FUNC_LOAD, 12'hfff, 64'h8000_0000_0000_0000);
                    gen_phase = 1;
                end
            endcase
            dir_idx++;
        end else if (gen_phase == 1) begin
            if (issued >= 900) begin
                gen_fault();
                gen_phase = 2;
            end else if ($urandom % 6 == 0) begin
                gen_noise();
            end else if (sb.ip > 4000) begin
                gen_instr(($urandom % 2) ? OP_JT : OP_JF, 1'b0);
            end else begin
                gen_instr(ops_all[$urandom_range(0, 8)], $urandom % 4 == 0);
            end
        end
    endfunction

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Sender: bursts of beats with random gaps, one pause until drained.
    initial begin
        t_beat cur;
        bit    busy;
        bit    pause_done;
        int    burst_left;
        int    gap_left;
        busy = 1'b0;
        pause_done = 1'b0;
        burst_left = 5;
        gap_left = 0;
        i_in_valid <= 1'b0;
        i_func <= FUNC_LOAD;
        i_address <= '0;
        i_value <= '0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (i_in_valid && !o_in_stall) begin
                sb.note_beat(cur);
                busy = 1'b0;
            end
            if (busy) begin
                // Hold the beat until it is taken.
            end else if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (!pause_done && issued >= 600) begin
                i_in_valid <= 1'b0;
                if (sb.owed.size() == 0) pause_done = 1'b1;
            end else begin
                if (pend.size() == 0) refill();
                if (pend.size() == 0) begin
                    i_in_valid <= 1'b0;
                    drive_done = 1'b1;
                end else begin
                    cur = pend.pop_front();
                    issued++;
                    i_func <= cur.func;
                    i_address <= cur.addr;
                    i_value <= cur.value;
                    i_in_valid <= 1'b1;
                    busy = 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 20);
                        gap_left = ($urandom % 3 == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
            @(posedge i_clk);
        end
    end

    // Receiver: checks result beats and stalls in changing patterns.
    initial begin
        t_res got;
        int   hold_left;
        bit   hold_done;
        int   stall_mode;
        int   mode_left;
        hold_left = 0;
        hold_done = 1'b0;
        stall_mode = 0;
        mode_left = 50;
        i_res_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_res_valid && !i_res_stall) begin
                got.ov = o_out_valid;
                got.oval = o_out_value;
                got.halted = o_halted;
                got.waiting = o_waiting;
                got.status = o_status;
                sb.check_result(got);
            end
            if (!hold_done && sb.n_in >= 300) begin
                hold_left = 400;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_res_stall <= 1'b1;
            end else begin
                mode_left--;
                if (mode_left <= 0) begin
                    stall_mode = $urandom % 3;
                    mode_left = $urandom_range(20, 200);
                end
                if (stall_mode == 0) i_res_stall <= 1'b0;
                else if (stall_mode == 1) i_res_stall <= ($urandom % 4 == 0);
                else i_res_stall <= ($urandom % 4 != 0);
            end
        end
    end

    // Run limit.
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("FAIL");
        $finish;
    end

    // Reset, then wait for the sender and the owed results to drain.
    initial begin
        sb = new();
        issued = 0;
        gen_phase = 0;
        dir_idx = 0;
        drive_done = 1'b0;
        i_rst_n <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (drive_done);
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (sb.owed.size() != 0) sb.report("results still expected at end of run");
        if (sb.errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

endmodule
